// File: design/lud_pkg.sv
// shared types and constants for the least used unit dispatcher
`default_nettype none

package lud_pkg;

    localparam int MASK_WIDTH  = 64;
    localparam int INDEX_WIDTH = 6;
    localparam int CFG_WIDTH   = 7;
    localparam int POP_WIDTH   = 7;
    localparam int STAT_WIDTH  = 2;

    localparam logic [STAT_WIDTH-1:0] STATUS_OK            = 2'd0;
    localparam logic [STAT_WIDTH-1:0] STATUS_TOO_MANY      = 2'd1;
    localparam logic [STAT_WIDTH-1:0] STATUS_NONE_RESERVED = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } lud_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_idx;
        logic out_free;
    } lud_stat_t;

endpackage

`default_nettype wire

// File: design/lud_ctrl.sv
// controller state machine for the least used unit dispatcher
`default_nettype none

module lud_ctrl
    import lud_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire lud_stat_t stat,
    output lud_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.last_idx)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/lud_dpath.sv
// datapath: counter memory, scan comparator, popcount and result register
`default_nettype none

module lud_dpath
    import lud_pkg::*;
#(
    parameter int UNIT_COUNT  = 64,
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [2*MASK_WIDTH-1:0] s_tdata,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_WIDTH-1:0]    cfg_data,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [7:0]                   m_tdata,
    input  wire lud_cmd_t                cmd,
    output lud_stat_t                    stat
);

    localparam int AW = $clog2(UNIT_COUNT);

    logic [CFG_WIDTH-1:0]   units_present_reg;
    logic [MASK_WIDTH-1:0]  req_reg;
    logic [MASK_WIDTH-1:0]  res_reg;
    logic [INDEX_WIDTH-1:0] idx_reg;

    // counter store, valid bits stand in for the reset clear
    logic [COUNT_WIDTH-1:0] mem [UNIT_COUNT];
    logic [UNIT_COUNT-1:0]  valid_reg;
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic                   rvalid_reg;

    logic                   s1_valid_reg;
    logic [INDEX_WIDTH-1:0] s1_idx_reg;
    logic                   s1_cand_reg;
    logic                   s1_req_reg;

    logic [POP_WIDTH-1:0]   pop_reg;
    logic                   found_reg;
    logic [INDEX_WIDTH-1:0] best_idx_reg;
    logic [COUNT_WIDTH-1:0] best_cnt_reg;

    logic                   out_valid_reg;
    logic [INDEX_WIDTH-1:0] chosen_reg;
    logic [STAT_WIDTH-1:0]  status_reg;

    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic                   in_range;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic                   better;
    logic                   too_many;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] sat_cnt;

    assign rd_addr  = idx_reg[AW-1:0];
    assign wr_addr  = best_idx_reg[AW-1:0];
    assign in_range = ({1'b0, idx_reg} < (INDEX_WIDTH+1)'(UNIT_COUNT));
    assign cur_cnt  = rvalid_reg ? rdata_reg : '0;
    assign better   = s1_valid_reg && s1_cand_reg && (!found_reg || (cur_cnt < best_cnt_reg));
    assign too_many = (pop_reg > units_present_reg);
    assign wr_en    = cmd.finish && !too_many && found_reg;
    assign sat_cnt  = (&best_cnt_reg) ? best_cnt_reg : best_cnt_reg + COUNT_WIDTH'(1);

    assign cfg_ready     = 1'b1;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {status_reg, chosen_reg};
    assign stat.last_idx = &idx_reg;
    assign stat.out_free = !out_valid_reg || m_tready;

    // memory read and write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= sat_cnt;
        end
        rdata_reg  <= mem[rd_addr];
        rvalid_reg <= valid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_present_reg <= '0;
            valid_reg         <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                units_present_reg <= cfg_data;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            s1_valid_reg <= cmd.step;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan datapath
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= s_tdata[MASK_WIDTH-1:0];
            res_reg   <= s_tdata[2*MASK_WIDTH-1:MASK_WIDTH];
            idx_reg   <= '0;
            pop_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                idx_reg <= idx_reg + INDEX_WIDTH'(1);
            end
            if (s1_valid_reg)
            begin
                pop_reg <= pop_reg + POP_WIDTH'(s1_req_reg);
            end
            if (better)
            begin
                found_reg    <= 1'b1;
                best_idx_reg <= s1_idx_reg;
                best_cnt_reg <= cur_cnt;
            end
        end
        s1_idx_reg  <= idx_reg;
        s1_req_reg  <= req_reg[idx_reg];
        s1_cand_reg <= in_range && req_reg[idx_reg] && res_reg[idx_reg];
        if (cmd.finish)
        begin
            if (too_many)
            begin
                status_reg <= STATUS_TOO_MANY;
                chosen_reg <= '0;
            end
            else if (!found_reg)
            begin
                status_reg <= STATUS_NONE_RESERVED;
                chosen_reg <= '0;
            end
            else
            begin
                status_reg <= STATUS_OK;
                chosen_reg <= best_idx_reg;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/least_used_unit_dispatch_top.sv
// top level of the least used unit dispatcher
// flow: an accepted request is scanned, the pipeline drains, then the result waits for a free output register
// a new request is taken only after the previous result is loaded into the output register, since the single
//   comparator walks the 64 mask positions through the one read port of the counter memory
// reset: rst_n async active low; units_present clears to 0 and all usage
//   counters read as zero through per-unit valid bits, no clearing pass
`default_nettype none

module least_used_unit_dispatch_top
    import lud_pkg::*;
#(
    parameter int UNIT_COUNT  = 64,
    parameter int COUNT_WIDTH = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // request_mask [63:0], reserved_mask [127:64]
    // units_present write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [6:0]   cfg_data,  // units_present [6:0]
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata    // chosen_unit [5:0], status [7:6]
);

    lud_cmd_t  cmd;
    lud_stat_t stat;

    // controller: idle, scan of all mask positions, pipeline drain, result handoff
    lud_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: counter memory with registered read, running min and popcount
    lud_dpath #(
        .UNIT_COUNT  (UNIT_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    // only one command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.finish}))
        else $error("overlapping controller commands");

    // an accepted request blocks the input until its result is loaded into the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // error results carry unit zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[7:6] != STATUS_OK)) |-> (m_tdata[5:0] == 6'd0))
        else $error("error result with nonzero unit");

    // a result is loaded only when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!m_tvalid || m_tready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the least used unit dispatcher
`timescale 1ns / 1ps

module tb
    import lud_pkg::*;
();

    localparam int UNITS          = 64;
    localparam int USAGE_WIDTH    = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int MAX_GAP        = 150;

    typedef struct packed {
        logic [STAT_WIDTH-1:0]  status;
        logic [INDEX_WIDTH-1:0] unit;
    } dispatch_result_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata   = '0;   // request_mask [63:0], reserved_mask [127:64]
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [6:0]   cfg_data  = '0;   // units_present [6:0]
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [7:0]   m_tdata;          // chosen_unit [5:0], status [7:6]

    // predictor state
    logic [USAGE_WIDTH-1:0] unit_usage [UNITS];
    logic [CFG_WIDTH-1:0]   units_present;
    dispatch_result_t       pending_results [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int gap_pct        = 0;
    int stall_pct      = 0;

    always #2 clk = ~clk;

    least_used_unit_dispatch_top #(
        .UNIT_COUNT  (UNITS),
        .COUNT_WIDTH (USAGE_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // least loaded pick among units allowed by both masks, lowest index on ties; too many requests are refused
    function automatic dispatch_result_t predict_dispatch(input logic [63:0] req,
                                                          input logic [63:0] res);
        dispatch_result_t r;
        logic [63:0]      usable;
        int               best;
        r.unit   = '0;
        r.status = STATUS_OK;
        best     = -1;
        if ($countones(req) > units_present)
            r.status = STATUS_TOO_MANY;
        else
        begin
            usable = req & res;
            for (int i = 0; i < UNITS; i++)
                if (usable[i] && (best < 0 || unit_usage[i] < unit_usage[best]))
                    best = i;
            if (best < 0)
                r.status = STATUS_NONE_RESERVED;
            else
            begin
                // counter holds at all ones
                if (unit_usage[best] != {USAGE_WIDTH{1'b1}})
                    unit_usage[best] = unit_usage[best] + 1'b1;
                r.unit = 6'(best);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // transfer monitor: config and requests feed the predictor, results are checked
    always @(posedge clk)
    begin
        dispatch_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                units_present = cfg_data;
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_dispatch(s_tdata[63:0], s_tdata[127:64]));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result 0x%02h", m_tdata));
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[7:6] !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_tdata[7:6], want.status));
                    if (m_tdata[5:0] !== want.unit)
                        report_mismatch($sformatf("chosen_unit got %0d want %0d",
                                                  m_tdata[5:0], want.unit));
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // ends the run when no transfer happens for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one request transfer; valid stays high afterwards unless a gap follows
    task automatic send_request(input logic [63:0] req, input logic [63:0] res);
        int gap;
        gap = 0;
        if ($urandom_range(99) < gap_pct)
            gap = $urandom_range(1, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {res, req};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
    endtask

    task automatic write_units_present(input logic [CFG_WIDTH-1:0] value);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] mask_of_weight(input int k);
        logic [63:0] m;
        if (k > 32)
        begin
            m = '1;
            while ($countones(m) > k)
                m[$urandom_range(63)] = 1'b0;
        end
        else
        begin
            m = '0;
            while ($countones(m) < k)
                m[$urandom_range(63)] = 1'b1;
        end
        return m;
    endfunction

    // units_present is still zero: nonzero requests refused, empty request has no unit
    task automatic test_reset_state();
        send_request('0, '0);
        send_request(64'h8000_0000_0000_0000, '1);
        send_request('1, '1);
        send_request(64'h1, '0);
    endtask

    // popcount against units_present, at the edges and above 64
    task automatic test_popcount_limit();
        write_units_present(7'd1);
        send_request(64'h8000_0000_0000_0000, '1);
        send_request(64'h3, '1);
        send_request(64'h1, '0);
        write_units_present(7'd5);
        send_request(64'h1F, '1);
        send_request(64'h3F, '1);
        write_units_present(7'd127);
        send_request('1, '1);
        send_request('1, '0);
        write_units_present(7'd64);
        send_request('1, '1);
    endtask

    // ties by lowest index and movement of the least loaded unit
    task automatic test_selection_ties();
        send_request('1, 64'h8000_0000_0000_0001);
        send_request('1, 64'h8000_0000_0000_0001);
        send_request('1, 64'h8000_0000_0000_0001);
        send_request(64'hF0, '1);
        send_request(64'hF0, '1);
        send_request(64'hF0, 64'h80);
        send_request(64'hF0, '1);
        send_request(64'hF0, '1);
        send_request('0, '1);
        send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request('1, '1);
    endtask

    task automatic test_random_traffic();
        int          phase_units [8] = '{64, 127, 3, 32, 1, 0, 48, 0};
        int          gap_modes   [4] = '{0, 78, 0, 32};
        int          stall_modes [4] = '{0, 0, 78, 32};
        int          up;
        int          lim;
        int          count;
        int          kind;
        int          k;
        logic [63:0] hot_pool;
        logic [63:0] req;
        logic [63:0] res;
        phase_units[7] = $urandom_range(2, 126);
        for (int p = 0; p < 8; p++)
        begin
            up = phase_units[p];
            lim = (up > 64) ? 64 : up;
            count = (up == 0) ? 40 : 122;
            write_units_present(CFG_WIDTH'(up));
            gap_pct   = gap_modes[p % 4];
            stall_pct = stall_modes[p % 4];
            // a few hot units so their counters pull apart from the rest
            hot_pool = mask_of_weight((lim < 8) ? lim : 8);
            for (int n = 0; n < count; n++)
            begin
                // sender holds off until the dispatcher has drained
                if (n % 40 == 39)
                    wait_all_results();
                kind = $urandom_range(99);
                if (kind < 45)
                begin
                    k = (lim == 0) ? 0 : $urandom_range(1, lim);
                    req = mask_of_weight(k);
                    res = rand_word();
                    if ($urandom_range(1))
                        res = res | (req & rand_word());
                end
                else if (kind < 70)
                begin
                    req = hot_pool & rand_word();
                    res = rand_word() | (hot_pool & rand_word());
                end
                else if (kind < 80 && lim < 64)
                begin
                    req = mask_of_weight($urandom_range(lim + 1, 64));
                    res = rand_word();
                end
                else if (kind < 90)
                begin
                    req = mask_of_weight((lim == 0) ? 0 : $urandom_range(1, lim));
                    res = ~req & rand_word();
                end
                else
                begin
                    req = rand_word();
                    res = rand_word();
                end
                send_request(req, res);
            end
        end
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        units_present = '0;
        for (int i = 0; i < UNITS; i++)
            unit_usage[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_popcount_limit();
        test_selection_ties();
        test_random_traffic();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
design/lud_pkg.sv
design/lud_ctrl.sv
design/lud_dpath.sv
design/least_used_unit_dispatch_top.sv
tb/tb.sv
